FILE: rtl/itx_pkg.sv
// itx_pkg: shared constants and types of the indexed texture to argb4444 decoder
// no dependencies; used by indexed_texture_to_argb4444 to size its palette memory
`default_nettype none

package itx_pkg;

  // number of palette entries that are backed by storage
  localparam int unsigned PalDepth = 256;
  localparam int unsigned PalAw    = (PalDepth > 1) ? $clog2(PalDepth) : 1;
  // palette entry: red, green, blue bytes
  localparam int unsigned PalWidth = 24;

  typedef enum logic [1:0] {
    OpPalWrite = 2'd0,
    OpDirect   = 2'd1,
    OpPair     = 2'd2,
    OpByte     = 2'd3
  } opcode_e;

endpackage : itx_pkg

`default_nettype wire

FILE: rtl/itx_ram.sv
// itx_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies; contents are undefined until written
`default_nettype none

module itx_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule : itx_ram

`default_nettype wire

FILE: rtl/indexed_texture_to_argb4444.sv
// indexed_texture_to_argb4444: decodes texture items into argb4444 pixels
// depends on itx_pkg and itx_ram (palette storage)
`default_nettype none

// The decoder accepts one item per cycle unless stage 1 is full and the output
// register cannot take its pixel. A palette write or a run-count load produces
// no pixel; a direct pixel or an indexed byte produces one pixel; an indexed
// pair produces two pixels, its first and then its final one, so a stream of
// pairs is bounded by the single output port. An accepted item is registered
// into stage 1 while its palette read is registered, and its pixel is then
// formatted into the output register once that register is free. The palette
// memory has a registered read (both indices of a pair are read in the same
// cycle over two read ports). A finished pixel waiting in the output register
// does not stop the next item from being accepted into the palette-read stage.
// Palette writes commit at their own accept edge, so a later item always reads
// the new entry with no forwarding. The palette has no reset or clearing pass;
// reading an entry that was never written returns arbitrary color. Indices at
// or beyond the palette depth read as black and writes there are dropped. The
// run count resets to zero and is cleared by start of image.
module indexed_texture_to_argb4444 (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic       start_of_image_i,
  input  wire logic [7:0] slot_a_i,
  input  wire logic [7:0] slot_b_i,
  input  wire logic [7:0] slot_c_i,
  input  wire logic [7:0] slot_d_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [15:0]     pixel_o,
  output logic            last_o
);

  import itx_pkg::*;

  // item waiting on its palette read
  typedef struct packed {
    opcode_e     op;
    logic [3:0]  alpha0;   // alpha nibble of the first (or only) pixel
    logic [3:0]  alpha1;   // alpha nibble of the second pixel of a pair
    logic        oob0;     // first index beyond the palette
    logic        oob1;     // second index beyond the palette
    logic        excess;   // direct pixel with doubled alpha above 255
    logic [7:0]  excess_amt;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
  } s1_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  opcode_e op;
  logic    in_acc;
  logic    has_result;
  logic    run_load;
  logic    run_hit;
  logic [4:0] run_eff;
  logic [4:0] run_d, run_q;
  logic [4:0] byte_idx;
  logic [7:0] rd_idx_a;
  logic       s1_valid_q;
  s1_t        s1_d, s1_q;
  logic       s1_adv;
  logic       out_free;

  logic       out_valid_q;
  logic       out_pair_q;  // showing the first pixel of a pair
  logic [15:0] pix0_q, pix1_q;

  logic                ram_we;
  logic                ram_re;
  logic [PalWidth-1:0] rdata_a, rdata_b;
  logic [PalWidth-1:0] rgb_a, rgb_b;
  logic [15:0]         pix_a, pix_b, pix_direct;
  logic [7:0]          q_r, q_g, q_b;
  logic [8:0]          r_sum;
  logic [7:0]          r_sat;

  assign op       = opcode_e'(opcode_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign byte_idx = slot_a_i[7:3];

  // ---------------------------------------------------------------------------
  // run count: a zero-alpha indexed byte with a nonzero index loads it,
  // other indexed bytes consume it
  // ---------------------------------------------------------------------------
  assign run_eff  = start_of_image_i ? 5'd0 : run_q;
  assign run_load = (op == OpByte) && (slot_a_i[2:0] == 3'd0) && (byte_idx != 5'd0);
  assign run_hit  = (op == OpByte) && !run_load && (run_eff != 5'd0);

  always_comb begin
    run_d = run_eff;
    if (run_load) begin
      run_d = byte_idx;
    end else if (run_hit) begin
      run_d = run_eff - 5'd1;
    end
  end

  assign has_result = (op != OpPalWrite) && !run_load;

  // ---------------------------------------------------------------------------
  // palette access at accept
  // ---------------------------------------------------------------------------
  assign rd_idx_a = (op == OpByte) ? {3'd0, byte_idx} : slot_a_i;
  assign ram_we   = in_acc && (op == OpPalWrite) && ({1'b0, slot_a_i} < 9'(PalDepth));
  assign ram_re   = in_acc && ((op == OpPair) || (op == OpByte)) && !run_load;

  itx_ram #(
    .WIDTH (PalWidth),
    .DEPTH (PalDepth)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (slot_a_i[PalAw-1:0]),
    .wdata_i   ({slot_b_i, slot_c_i, slot_d_i}),
    .re_i      (ram_re),
    .raddr_a_i (rd_idx_a[PalAw-1:0]),
    .raddr_b_i (slot_b_i[PalAw-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // ---------------------------------------------------------------------------
  // stage 1 capture: alpha nibbles, range flags and the direct-pixel products
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_d            = '0;
    s1_d.op         = op;
    s1_d.oob0       = ({1'b0, rd_idx_a} >= 9'(PalDepth));
    s1_d.oob1       = ({1'b0, slot_b_i} >= 9'(PalDepth));
    s1_d.excess     = slot_d_i[7];
    // doubled alpha minus 255, valid when the excess path is taken
    s1_d.excess_amt = {slot_d_i[6:0], 1'b1};
    s1_d.blue       = slot_a_i;
    s1_d.green      = slot_b_i;
    s1_d.red        = slot_c_i;
    s1_d.prod_r     = 16'(slot_c_i) * 16'(s1_d.excess_amt);
    s1_d.prod_g     = 16'(slot_b_i) * 16'(s1_d.excess_amt);
    s1_d.prod_b     = 16'(slot_a_i) * 16'(s1_d.excess_amt);
    case (op)
      OpDirect: begin
        // alpha bit 4 is always cleared; saturated alpha 0xef gives nibble 0xe
        s1_d.alpha0 = slot_d_i[7] ? 4'hE : {slot_d_i[6:4], 1'b0};
      end
      OpPair: begin
        s1_d.alpha0 = slot_c_i[7:4];
        s1_d.alpha1 = slot_c_i[3:0];
      end
      OpByte: begin
        s1_d.alpha0 = {slot_a_i[2:0], run_hit};
      end
      default: begin
        s1_d.alpha0 = 4'h0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: stage 1 drains when the output register is empty or handing
  // over its final pixel
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || (out_ready_i && !out_pair_q);
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 5'd0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        run_q <= run_d;
      end
      if (in_acc && has_result) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && has_result) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // pixel formatting
  // ---------------------------------------------------------------------------
  assign rgb_a = s1_q.oob0 ? '0 : rdata_a;
  assign rgb_b = s1_q.oob1 ? '0 : rdata_b;
  assign pix_a = {s1_q.alpha0, rgb_a[23:20], rgb_a[15:12], rgb_a[7:4]};
  assign pix_b = {s1_q.alpha1, rgb_b[23:20], rgb_b[15:12], rgb_b[7:4]};

  // excess path: scale colors by excess / 255, then add excess to red
  assign q_r   = div255(s1_q.prod_r);
  assign q_g   = div255(s1_q.prod_g);
  assign q_b   = div255(s1_q.prod_b);
  assign r_sum = 9'(q_r) + 9'(s1_q.excess_amt);
  assign r_sat = r_sum[8] ? 8'hFF : r_sum[7:0];

  assign pix_direct = s1_q.excess
                    ? {s1_q.alpha0, r_sat[7:4], q_g[7:4], q_b[7:4]}
                    : {s1_q.alpha0, s1_q.red[7:4], s1_q.green[7:4], s1_q.blue[7:4]};

  // ---------------------------------------------------------------------------
  // output register; a pair shows pix0 first, every final pixel comes from pix1
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_pair_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        out_pair_q  <= (s1_q.op == OpPair);
      end else if (out_valid_q && out_ready_i) begin
        if (out_pair_q) begin
          out_pair_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pix0_q <= pix_a;
      case (s1_q.op)
        OpPair:  pix1_q <= pix_b;
        OpByte:  pix1_q <= pix_a;
        default: pix1_q <= pix_direct;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = out_pair_q ? pix0_q : pix1_q;
  assign last_o      = !out_pair_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the first pixel of a pair is always followed by its final pixel
  a_pair_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && last_o)
    else $error("pair lost its second pixel");

  // a palette read always lands in stage 1 with an indexed item
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> s1_valid_q && (s1_q.op == OpPair || s1_q.op == OpByte))
    else $error("palette read without an indexed item in stage 1");

  // input stalls only when both stages are occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o)
    else $error("input stalled with a free stage");

endmodule : indexed_texture_to_argb4444

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for indexed_texture_to_argb4444, directed and random items
// depends on itx_pkg and the decoder rtl; keeps its own palette and run count to predict pixels
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itx_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned MAX_GAP        = 40;

  // one input item as the sender drives it
  typedef struct packed {
    opcode_e    op;
    logic       soi;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
  } tex_item_t;

  // one expected pixel
  typedef struct packed {
    logic [15:0] pixel;
    logic        last;
  } pixel_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  tex_item_t   drive_item;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] pixel_o;
  logic        last_o;

  // decoder model state, updated at each accepted item
  logic [23:0] palette_model [PalDepth];
  logic [4:0]  run_left;
  pixel_t      pending_pixels [$];

  // sender side: which palette slots hold a known color
  bit          slot_written [PalDepth];
  int unsigned written_slots [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned errors;

  indexed_texture_to_argb4444 uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (drive_item.op),
    .start_of_image_i(drive_item.soi),
    .slot_a_i        (drive_item.a),
    .slot_b_i        (drive_item.b),
    .slot_c_i        (drive_item.c),
    .slot_d_i        (drive_item.d),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_o         (pixel_o),
    .last_o          (last_o)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // pixel prediction
  // ---------------------------------------------------------------------------

  // keep the high nibble of each channel, alpha on top
  function automatic logic [15:0] argb4444(input logic [7:0] alpha, input logic [23:0] rgb);
    return {alpha[7:4], rgb[23:20], rgb[15:12], rgb[7:4]};
  endfunction

  // slots past the palette depth read as black
  function automatic logic [23:0] palette_lookup(input int unsigned idx);
    if (idx >= PalDepth) return '0;
    return palette_model[idx];
  endfunction

  // apply one accepted item to the model and queue the pixels it produces
  task automatic decode_item(input tex_item_t it);
    int unsigned alpha;
    int unsigned red;
    int unsigned grn;
    int unsigned blu;
    int unsigned excess;
    logic [7:0]  byte_alpha;
    logic [4:0]  idx;
    if (it.soi) run_left = '0;
    case (it.op)
      OpPalWrite: begin
        if (it.a < PalDepth) palette_model[it.a] = {it.b, it.c, it.d};
      end
      OpDirect: begin
        blu   = it.a;
        grn   = it.b;
        red   = it.c;
        alpha = 2 * it.d;
        // alpha beyond full scale brightens: colors scaled by the excess, red gets it added
        if (alpha > 255) begin
          excess = alpha - 255;
          red    = red * excess / 255;
          grn    = grn * excess / 255;
          blu    = blu * excess / 255;
          red    = red + excess;
          if (red > 255) red = 255;
          alpha  = 255;
        end
        alpha = alpha & 8'hEF;
        pending_pixels.push_back('{pixel: argb4444(8'(alpha), {8'(red), 8'(grn), 8'(blu)}),
                                   last: 1'b1});
      end
      OpPair: begin
        pending_pixels.push_back('{pixel: argb4444({it.c[7:4], 4'h0}, palette_lookup(it.a)),
                                   last: 1'b0});
        pending_pixels.push_back('{pixel: argb4444({it.c[3:0], 4'h0}, palette_lookup(it.b)),
                                   last: 1'b1});
      end
      default: begin
        idx        = it.a[7:3];
        byte_alpha = {it.a[2:0], 5'b0};
        // zero alpha with a nonzero index loads the run count instead of drawing
        if (byte_alpha == 8'h00 && idx != 5'd0) begin
          run_left = idx;
        end else begin
          if (run_left != 5'd0) begin
            byte_alpha[4] = 1'b1;
            run_left      = run_left - 5'd1;
          end
          pending_pixels.push_back('{pixel: argb4444(byte_alpha, palette_lookup(idx)),
                                     last: 1'b1});
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predict on input accept, check on output accept
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_item(drive_item);
      if (out_valid_o && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          errors++;
          $display("%0t ns: pixel with no item waiting: expected none, actual %h last %b",
                   $time, pixel_o, last_o);
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_o !== want.pixel) begin
            errors++;
            $display("%0t ns: pixel mismatch: expected %h, actual %h",
                     $time, want.pixel, pixel_o);
          end
          if (last_o !== want.last) begin
            errors++;
            $display("%0t ns: last mismatch: expected %b, actual %b",
                     $time, want.last, last_o);
          end
        end
      end
    end
  end

  // watchdog: ends the run when nothing moves on either side for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  function automatic tex_item_t tex_item(input opcode_e op, input logic soi,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d);
    return '{op: op, soi: soi, a: a, b: b, c: c, d: d};
  endfunction

  // random palette slot below limit that already holds a color; slot 0 is always written
  function automatic int unsigned pick_written(input int unsigned limit);
    int unsigned slot;
    repeat (16) begin
      slot = written_slots[$urandom_range(written_slots.size() - 1)];
      if (slot < limit) return slot;
    end
    return 0;
  endfunction

  // offer one item after a random gap and return at the edge that accepts it
  task automatic send_item(input tex_item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    drive_item <= it;
    in_valid_i <= 1'b1;
    if (it.op == OpPalWrite && it.a < PalDepth && !slot_written[it.a]) begin
      slot_written[it.a] = 1'b1;
      written_slots.push_back(it.a);
    end
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic release_bus();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // stop offering and wait for every predicted pixel
  task automatic wait_drained();
    release_bus();
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // mostly drawing items, every index taken from slots with a known color
  function automatic tex_item_t random_item();
    tex_item_t   it;
    int unsigned pick;
    it      = tex_item(OpPalWrite, ($urandom_range(99) < 5), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
    pick    = $urandom_range(99);
    if (pick < 15) begin
      it.op = OpPalWrite;
    end else if (pick < 40) begin
      it.op = OpDirect;
    end else if (pick < 65) begin
      it.op = OpPair;
      it.a  = 8'(pick_written(256));
      it.b  = 8'(pick_written(256));
    end else begin
      it.op = OpByte;
      if ($urandom_range(99) < 15) it.a = {5'($urandom_range(31, 1)), 3'b000};
      else it.a = {5'(pick_written(32)), 3'($urandom_range(7))};
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // palette entries at both ends of the slot range and with extreme colors
  task automatic test_palette_writes();
    send_item(tex_item(OpPalWrite, 1'b1, 8'd0,   8'hFF, 8'h00, 8'hFF));
    send_item(tex_item(OpPalWrite, 1'b0, 8'd31,  8'h12, 8'h34, 8'h56));
    send_item(tex_item(OpPalWrite, 1'b0, 8'd255, 8'hFF, 8'hFF, 8'hFF));
    send_item(tex_item(OpPalWrite, 1'b0, 8'd1,   8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpPalWrite, 1'b0, 8'd128, 8'hA5, 8'h5A, 8'hC3));
  endtask

  // half alpha around the excess threshold, alpha bit 4 clearing, red saturation
  task automatic test_direct_pixels();
    send_item(tex_item(OpDirect, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpDirect, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h7F));
    send_item(tex_item(OpDirect, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h80));
    send_item(tex_item(OpDirect, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(tex_item(OpDirect, 1'b0, 8'h40, 8'h80, 8'hC0, 8'h08));
    send_item(tex_item(OpDirect, 1'b0, 8'h10, 8'h20, 8'hFF, 8'hC8));
  endtask

  // both pixels of a pair, alpha nibbles at their extremes
  task automatic test_indexed_pairs();
    send_item(tex_item(OpPair, 1'b0, 8'd0,   8'd255, 8'hF0, 8'h00));
    send_item(tex_item(OpPair, 1'b0, 8'd31,  8'd128, 8'h0F, 8'hFF));
    send_item(tex_item(OpPair, 1'b0, 8'd255, 8'd0,   8'hA5, 8'h5A));
  endtask

  // index zero with zero alpha draws; run loads mark the next pixels; start of image clears
  task automatic test_indexed_bytes();
    send_item(tex_item(OpByte,   1'b0, {5'd0,  3'd0}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd3,  3'd0}, 8'hFF, 8'hFF, 8'hFF));
    send_item(tex_item(OpByte,   1'b0, {5'd31, 3'd7}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd1,  3'd1}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd31, 3'd4}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd0,  3'd2}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd31, 3'd0}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd1,  3'd5}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b1, {5'd31, 3'd3}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpByte,   1'b0, {5'd4,  3'd0}, 8'h00, 8'h00, 8'h00));
    send_item(tex_item(OpDirect, 1'b1, 8'h80, 8'h40, 8'h20, 8'h10));
    send_item(tex_item(OpByte,   1'b0, {5'd0,  3'd1}, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // receiver holds off while the sender keeps pushing, so the input backs up
  task automatic test_output_stall();
    hold_requests++;
    test_random(30);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    drive_item    = '0;
    run_left      = '0;
    hold_requests = 0;
    holds_served  = 0;
    hold_left     = 0;
    errors        = 0;
    send_idle_pct = 8;
    recv_idle_pct = 81;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    test_palette_writes();
    test_direct_pixels();
    test_indexed_pairs();
    test_indexed_bytes();
    test_random(500);
    wait_drained();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 81;
    recv_idle_pct = 8;
    test_random(500);
    wait_drained();

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_random(470);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
